### src/clx_pkg.sv
// shared types and constants of the c source lexical classifier
package clx_pkg;

    // run lengths up to the largest word buffer plus one
    localparam int RUN_CNT_W = 7;

    // style codes of the result channel
    localparam logic [2:0] ST_NORMAL  = 3'd0;
    localparam logic [2:0] ST_KEYWORD = 3'd1;
    localparam logic [2:0] ST_STRING  = 3'd2;
    localparam logic [2:0] ST_COMMENT = 3'd3;
    localparam logic [2:0] ST_NUMBER  = 3'd4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } clx_in_t;

    typedef struct packed {
        logic [2:0] style_code;
        logic       last_of_line;
    } clx_out_t;

    // results of one input byte: a run of equal styles, then up to two singles
    typedef struct packed {
        logic [RUN_CNT_W-1:0] run_cnt;
        logic [2:0]           run_style;
        logic [1:0]           single_cnt;
        logic [2:0]           single0;
        logic [2:0]           single1;
        logic                 line_last;
    } clx_desc_t;

endpackage

### src/clx_front.sv
// front end: lexer state machine that turns each byte into a result descriptor
module clx_front #(
    parameter int WORD_BUFFER_LEN = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  clx_pkg::clx_in_t    in_data,
    output logic                push,
    output clx_pkg::clx_desc_t  desc
);
    import clx_pkg::*;

    localparam int LW = $clog2(WORD_BUFFER_LEN + 1);
    localparam int KW_COUNT = 35;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_LINE   = 3'd1;
    localparam logic [2:0] MODE_BLOCK  = 3'd2;
    localparam logic [2:0] MODE_DQ     = 3'd3;
    localparam logic [2:0] MODE_SQ     = 3'd4;
    localparam logic [2:0] MODE_NUMBER = 3'd5;
    localparam logic [2:0] MODE_IDENT  = 3'd6;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // keyword text, last character in the low byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("auto"), 64'("break"), 64'("case"), 64'("char"), 64'("const"),
        64'("continue"), 64'("default"), 64'("do"), 64'("double"), 64'("else"),
        64'("enum"), 64'("extern"), 64'("float"), 64'("for"), 64'("goto"),
        64'("if"), 64'("int"), 64'("long"), 64'("register"), 64'("return"),
        64'("short"), 64'("signed"), 64'("sizeof"), 64'("static"),
        64'("struct"), 64'("switch"), 64'("typedef"), 64'("union"),
        64'("unsigned"), 64'("void"), 64'("volatile"), 64'("while"),
        64'("bool"), 64'("true"), 64'("false")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd6, 4'd4,
        4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2, 4'd3, 4'd4, 4'd8, 4'd6,
        4'd5, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4,
        4'd8, 4'd5, 4'd4, 4'd4, 4'd5
    };

    function automatic logic [7:0] kw_byte(input int k, input logic [2:0] p);
        logic [3:0] idx;
        idx = KW_LEN[k] - 4'd1 - {1'b0, p};
        return KW_TEXT[k][{idx[2:0], 3'b000} +: 8];
    endfunction

    function automatic logic is_kw(input logic [KW_COUNT-1:0] mask,
                                   input logic [LW-1:0] len);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (mask[k] && (len == LW'(KW_LEN[k])))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    logic [2:0]          mode_reg, mode_next;
    logic                held_v_reg, held_v_next;
    logic                held_slash_reg, held_slash_next;
    logic [LW-1:0]       len_reg, len_next;
    logic                long_reg, long_next;
    logic                bs_reg, bs_next;
    logic                star_reg, star_next;
    logic [KW_COUNT-1:0] mask_reg, mask_next;

    logic [7:0]          c;
    logic                is_digit, is_alpha, is_word, is_num;
    logic [LW-1:0]       pos;
    logic [KW_COUNT-1:0] step_match;
    logic [7:0]          quote;
    logic                do_fresh;
    logic [2:0]          flush_style;
    logic [2:0]          push_style;
    logic                push_single;
    logic [RUN_CNT_W-1:0] run_cnt;
    logic [2:0]          run_style;
    logic [1:0]          nsing;
    logic [2:0]          sing0, sing1;

    assign c        = in_data.char_code;
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign is_word  = is_alpha || is_digit || (c == CH_UNDER);
    assign is_num   = is_digit || (c == CH_DOT) || (c == 8'h65) || (c == 8'h45) ||
                      (c == 8'h78) || (c == 8'h58) || (c == 8'h66) || (c == 8'h46) ||
                      (c == 8'h6C) || (c == 8'h4C) || (c == 8'h75) || (c == 8'h55);

    // position of this byte within the identifier
    assign pos = (mode_reg == MODE_IDENT) ? len_reg : '0;

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            step_match[k] = (pos < LW'(KW_LEN[k])) && (kw_byte(k, pos[2:0]) == c);
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        held_v_next     = held_v_reg;
        held_slash_next = held_slash_reg;
        len_next        = len_reg;
        long_next       = long_reg;
        bs_next         = bs_reg;
        star_next       = star_reg;
        mask_next       = mask_reg;
        run_cnt         = '0;
        run_style       = ST_NORMAL;
        nsing           = 2'd0;
        sing0           = ST_NORMAL;
        sing1           = ST_NORMAL;
        do_fresh        = 1'b0;
        quote           = (mode_reg == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE;
        flush_style     = ST_NORMAL;
        push_style      = ST_NORMAL;
        push_single     = 1'b0;

        case (mode_reg)
            MODE_LINE:
            begin
                sing0 = ST_COMMENT;
                nsing = 2'd1;
            end
            MODE_BLOCK:
            begin
                sing0 = ST_COMMENT;
                nsing = 2'd1;
                if ((c == CH_SLASH) && star_reg)
                begin
                    mode_next = MODE_NORMAL;
                    star_next = 1'b0;
                end
                else
                begin
                    star_next = (c == CH_STAR);
                end
            end
            MODE_DQ, MODE_SQ:
            begin
                sing0 = ST_STRING;
                nsing = 2'd1;
                if ((c == quote) && !bs_reg)
                begin
                    mode_next = MODE_NORMAL;
                    bs_next   = 1'b0;
                end
                else
                begin
                    bs_next = (c == CH_BSLASH);
                end
            end
            MODE_NUMBER:
            begin
                if (is_num)
                begin
                    sing0 = ST_NUMBER;
                    nsing = 2'd1;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    do_fresh  = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_word)
                begin
                    if (long_reg)
                    begin
                        sing0 = ST_NORMAL;
                        nsing = 2'd1;
                    end
                    else if (len_reg < LW'(WORD_BUFFER_LEN))
                    begin
                        mask_next = mask_reg & step_match;
                        len_next  = len_reg + LW'(1);
                    end
                    else
                    begin
                        // word outgrew the buffer: release it all as normal
                        run_cnt   = RUN_CNT_W'(len_reg) + RUN_CNT_W'(1);
                        run_style = ST_NORMAL;
                        long_next = 1'b1;
                    end
                end
                else
                begin
                    if (!long_reg)
                    begin
                        run_cnt   = RUN_CNT_W'(len_reg);
                        run_style = is_kw(mask_reg, len_reg) ? ST_KEYWORD : ST_NORMAL;
                    end
                    len_next  = '0;
                    long_next = 1'b0;
                    mode_next = MODE_NORMAL;
                    do_fresh  = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                if (held_v_reg)
                begin
                    held_v_next = 1'b0;
                    if (held_slash_reg && (c == CH_SLASH))
                    begin
                        sing0     = ST_COMMENT;
                        sing1     = ST_COMMENT;
                        nsing     = 2'd2;
                        mode_next = MODE_LINE;
                    end
                    else if (held_slash_reg && (c == CH_STAR))
                    begin
                        sing0     = ST_COMMENT;
                        sing1     = ST_COMMENT;
                        nsing     = 2'd2;
                        mode_next = MODE_BLOCK;
                        star_next = 1'b0;
                    end
                    else if (!held_slash_reg && is_digit)
                    begin
                        sing0     = ST_NUMBER;
                        sing1     = ST_NUMBER;
                        nsing     = 2'd2;
                        mode_next = MODE_NUMBER;
                    end
                    else
                    begin
                        sing0    = ST_NORMAL;
                        nsing    = 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                else
                begin
                    do_fresh = 1'b1;
                end
            end
        endcase

        // byte seen in normal mode with nothing held
        if (do_fresh)
        begin
            if ((c == CH_SLASH) || (c == CH_DOT))
            begin
                held_v_next     = 1'b1;
                held_slash_next = (c == CH_SLASH);
            end
            else if (c == CH_DQUOTE)
            begin
                push_single = 1'b1;
                push_style  = ST_STRING;
                mode_next   = MODE_DQ;
                bs_next     = 1'b0;
            end
            else if (c == CH_SQUOTE)
            begin
                push_single = 1'b1;
                push_style  = ST_STRING;
                mode_next   = MODE_SQ;
                bs_next     = 1'b0;
            end
            else if (is_digit)
            begin
                push_single = 1'b1;
                push_style  = ST_NUMBER;
                mode_next   = MODE_NUMBER;
            end
            else if (is_alpha || (c == CH_UNDER))
            begin
                mask_next = step_match;
                len_next  = LW'(1);
                long_next = 1'b0;
                mode_next = MODE_IDENT;
            end
            else
            begin
                push_single = 1'b1;
                push_style  = ST_NORMAL;
            end
        end
        if (push_single)
        begin
            if (nsing == 2'd0)
            begin
                sing0 = push_style;
            end
            else
            begin
                sing1 = push_style;
            end
            nsing = nsing + 2'd1;
        end

        // line end: release a held byte and any pending word, then start fresh
        if (in_data.line_end)
        begin
            if (held_v_next)
            begin
                if (nsing == 2'd0)
                begin
                    sing0 = ST_NORMAL;
                end
                else
                begin
                    sing1 = ST_NORMAL;
                end
                nsing = nsing + 2'd1;
            end
            if ((mode_next == MODE_IDENT) && !long_next)
            begin
                flush_style = is_kw(mask_next, len_next) ? ST_KEYWORD : ST_NORMAL;
                if ((nsing == 2'd0) && (run_cnt == '0))
                begin
                    run_cnt   = RUN_CNT_W'(len_next);
                    run_style = flush_style;
                end
                else
                begin
                    // a one-letter word started by this byte
                    if (nsing == 2'd0)
                    begin
                        sing0 = flush_style;
                    end
                    else
                    begin
                        sing1 = flush_style;
                    end
                    nsing = nsing + 2'd1;
                end
            end
            mode_next   = MODE_NORMAL;
            held_v_next = 1'b0;
            len_next    = '0;
            long_next   = 1'b0;
            bs_next     = 1'b0;
            star_next   = 1'b0;
        end
    end

    assign desc.run_cnt    = run_cnt;
    assign desc.run_style  = run_style;
    assign desc.single_cnt = nsing;
    assign desc.single0    = sing0;
    assign desc.single1    = sing1;
    assign desc.line_last  = in_data.line_end;
    assign push = accept && ((run_cnt != '0) || (nsing != 2'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NORMAL;
            held_v_reg     <= 1'b0;
            held_slash_reg <= 1'b0;
            len_reg        <= '0;
            long_reg       <= 1'b0;
            bs_reg         <= 1'b0;
            star_reg       <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            held_v_reg     <= held_v_next;
            held_slash_reg <= held_slash_next;
            len_reg        <= len_next;
            long_reg       <= long_next;
            bs_reg         <= bs_next;
            star_reg       <= star_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mask_reg <= mask_next;
        end
    end

endmodule

### src/clx_queue.sv
// small descriptor queue between lexer front end and result expander
module clx_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  clx_pkg::clx_desc_t  push_data,
    output logic                full,
    input  logic                pop,
    output logic                nonempty,
    output clx_pkg::clx_desc_t  head
);
    import clx_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    clx_desc_t     mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/clx_back.sv
// back end: expands queued descriptors into one style result per cycle unless stalled
module clx_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  clx_pkg::clx_desc_t  head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output clx_pkg::clx_out_t   out_data
);
    import clx_pkg::*;

    logic [RUN_CNT_W-1:0] pos_reg, pos_next;
    logic [RUN_CNT_W-1:0] last_idx;
    logic [RUN_CNT_W-1:0] single_idx;
    logic                 out_valid_reg, out_valid_next;
    clx_out_t             out_reg;
    clx_out_t             item;
    logic                 emit;
    logic                 final_item;

    assign emit       = head_valid && (!out_valid_reg || !out_stall);
    assign last_idx   = head.run_cnt + RUN_CNT_W'(head.single_cnt) - RUN_CNT_W'(1);
    assign final_item = (pos_reg == last_idx);
    assign single_idx = pos_reg - head.run_cnt;
    assign pop        = emit && final_item;

    always_comb
    begin
        if (pos_reg < head.run_cnt)
        begin
            item.style_code = head.run_style;
        end
        else if (single_idx == '0)
        begin
            item.style_code = head.single0;
        end
        else
        begin
            item.style_code = head.single1;
        end
        item.last_of_line = head.line_last && final_item;

        pos_next = pos_reg;
        if (emit)
        begin
            pos_next = final_item ? '0 : pos_reg + RUN_CNT_W'(1);
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### src/c_source_lexical_classifier_top.sv
// top level of the c source lexical classifier
//
// char channel: one source byte per transaction, with line_end set on the
// last byte of each line; every line is lexed from a fresh state
// style channel: one style code per source byte, in byte order, with
// last_of_line set on the final result of a line
// a slash or dot waits for one byte of lookahead, and identifiers wait until
// they end, so results may trail their bytes; an identifier that ends a line
// comes out together with that line's last byte
// throughput: one byte accepted per cycle while the descriptor queue has room;
// results leave the expander at one per cycle while the receiver does not stall,
// so the n results of a closing identifier form a burst that the queue absorbs
// a result whose byte needs no lookahead is written into the queue at the byte's
// transaction and then registered in the output register
// reset clears the lexer mode and flags, the queue and the output valid flag
// when the receiver stalls, the output register holds its result, the queue
// fills, and char_stall rises once the queue is full
module c_source_lexical_classifier_top #(
    parameter int WORD_BUFFER_LEN = 8,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  clx_pkg::clx_in_t   char_data,
    output logic               style_valid,
    input  logic               style_stall,
    output clx_pkg::clx_out_t  style_data
);
    import clx_pkg::*;

    logic      accept;
    logic      push;
    logic      q_full;
    logic      q_nonempty;
    logic      pop;
    clx_desc_t desc;
    clx_desc_t head;

    // a byte is taken whenever the queue can hold its descriptor
    assign char_stall = q_full;
    assign accept     = char_valid && !q_full;

    // lexer state and per-byte result descriptor
    clx_front #(
        .WORD_BUFFER_LEN(WORD_BUFFER_LEN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_data (char_data),
        .push    (push),
        .desc    (desc)
    );

    // decouples byte intake from result bursts
    clx_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (desc),
        .full      (q_full),
        .pop       (pop),
        .nonempty  (q_nonempty),
        .head      (head)
    );

    // one result per cycle into the output register unless the receiver stalls
    clx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_nonempty),
        .head       (head),
        .pop        (pop),
        .out_valid  (style_valid),
        .out_stall  (style_stall),
        .out_data   (style_data)
    );

endmodule

### sim/tb.sv
// testbench of the c source lexical classifier: directed table plus random source lines
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clx_pkg::*;

    // style codes of the result channel
    typedef enum logic [2:0] {
        STY_NORMAL  = ST_NORMAL,
        STY_KEYWORD = ST_KEYWORD,
        STY_STRING  = ST_STRING,
        STY_COMMENT = ST_COMMENT,
        STY_NUMBER  = ST_NUMBER
    } style_e;

    // lexer modes tracked by the predictor
    typedef enum logic [2:0] {
        LX_NORMAL,
        LX_LINE,
        LX_BLOCK,
        LX_DQ,
        LX_SQ,
        LX_NUMBER,
        LX_IDENT
    } lex_mode_e;

    // one row of the directed table; typed rows carry their single expected style
    typedef struct {
        logic [7:0] chr;
        logic       eol;
        bit         typed;
        style_e     typed_style;
    } stim_row_t;

    localparam int WORD_MAX      = 8;
    localparam int KEYWORD_COUNT = 35;
    localparam int RANDOM_ITEMS  = 95;
    localparam int HOLD_CYCLES   = 80;
    localparam int TAIL_CYCLES   = 16;
    localparam int DIR_ROWS      = 25;

    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_DQUOTE = "\"";
    localparam logic [7:0] CH_SQUOTE = "'";
    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_SPACE  = " ";

    logic      clk;
    logic      rst_n;
    logic      char_valid;
    logic      char_stall;
    clx_in_t   char_data;
    logic      style_valid;
    logic      style_stall;
    clx_out_t  style_data;

    c_source_lexical_classifier_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_data   (char_data),
        .style_valid (style_valid),
        .style_stall (style_stall),
        .style_data  (style_data)
    );

    // directed rows: keyword at line end, high byte alone, lone slash at line end,
    // unterminated block comment whose opener star must not close it, escaped
    // quote inside a string, dot-digit number then line comment, over-long word
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{"i",    1'b0, 1'b0, STY_NORMAL},
        '{"f",    1'b1, 1'b0, STY_NORMAL},
        '{8'hFF,  1'b1, 1'b1, STY_NORMAL},
        '{"/",    1'b1, 1'b1, STY_NORMAL},
        '{"/",    1'b0, 1'b0, STY_NORMAL},
        '{"*",    1'b0, 1'b0, STY_NORMAL},
        '{"/",    1'b0, 1'b0, STY_NORMAL},
        '{"/",    1'b1, 1'b0, STY_NORMAL},
        '{"\"",   1'b0, 1'b0, STY_NORMAL},
        '{"\\",   1'b0, 1'b0, STY_NORMAL},
        '{"\"",   1'b0, 1'b0, STY_NORMAL},
        '{"\"",   1'b0, 1'b0, STY_NORMAL},
        '{".",    1'b0, 1'b0, STY_NORMAL},
        '{"5",    1'b0, 1'b0, STY_NORMAL},
        '{"/",    1'b0, 1'b0, STY_NORMAL},
        '{"/",    1'b1, 1'b0, STY_NORMAL},
        '{"q",    1'b0, 1'b0, STY_NORMAL},
        '{"u",    1'b0, 1'b0, STY_NORMAL},
        '{"a",    1'b0, 1'b0, STY_NORMAL},
        '{"l",    1'b0, 1'b0, STY_NORMAL},
        '{"i",    1'b0, 1'b0, STY_NORMAL},
        '{"f",    1'b0, 1'b0, STY_NORMAL},
        '{"i",    1'b0, 1'b0, STY_NORMAL},
        '{"e",    1'b0, 1'b0, STY_NORMAL},
        '{"d",    1'b1, 1'b0, STY_NORMAL}
    };

    // character sets for building random source lines
    string alpha_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string num_chars   = "0123456789.eExXfFlLuU";
    string digit_chars = "0123456789";
    string text_chars  = "abc xyz019_/*;,";
    string escape_chars = "\"'n\\0";
    string block_chars = "*/ab ";
    string punct_chars = " ;(),+-*/.=<>{}";

    // predictor state
    lex_mode_e   lx_mode;
    logic [7:0]  held_chr;
    bit          held_vld;
    logic [63:0] word_pack;
    int          word_len;
    bit          word_long;
    bit          prev_bslash;
    bit          prev_star;

    clx_out_t    step_styles [$];
    clx_out_t    pending_styles [$];
    logic [7:0]  line_buf [$];

    int  mismatches     = 0;
    int  bytes_sent     = 0;
    int  lines_sent     = 0;
    int  styles_checked = 0;
    int  keyword_styles = 0;
    int  quiet_left     = 0;
    bit  hold_off_req   = 1'b0;
    clx_out_t want_style;

    // ------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // far beyond the slowest correct run: ~130 bytes, each up to ten results,
    // each result waiting out the longest receiver stall
    initial
    begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // keyword list, packed right-aligned so a word compares by value
    // ------------------------------------------------------------------
    function automatic logic [63:0] keyword_at(int idx);
        case (idx)
            0:  return 64'("auto");
            1:  return 64'("break");
            2:  return 64'("case");
            3:  return 64'("char");
            4:  return 64'("const");
            5:  return 64'("continue");
            6:  return 64'("default");
            7:  return 64'("do");
            8:  return 64'("double");
            9:  return 64'("else");
            10: return 64'("enum");
            11: return 64'("extern");
            12: return 64'("float");
            13: return 64'("for");
            14: return 64'("goto");
            15: return 64'("if");
            16: return 64'("int");
            17: return 64'("long");
            18: return 64'("register");
            19: return 64'("return");
            20: return 64'("short");
            21: return 64'("signed");
            22: return 64'("sizeof");
            23: return 64'("static");
            24: return 64'("struct");
            25: return 64'("switch");
            26: return 64'("typedef");
            27: return 64'("union");
            28: return 64'("unsigned");
            29: return 64'("void");
            30: return 64'("volatile");
            31: return 64'("while");
            32: return 64'("bool");
            33: return 64'("true");
            default: return 64'("false");
        endcase
    endfunction

    // words never hold a zero byte, so equal values mean equal words
    function automatic bit is_keyword(logic [63:0] w);
        for (int k = 0; k < KEYWORD_COUNT; k++)
            if (keyword_at(k) == w)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word(logic [7:0] c);
        return is_alpha(c) || is_dig(c) || c == CH_UNDER;
    endfunction

    function automatic bit is_num_char(logic [7:0] c);
        return is_dig(c) || c == "." || c == "e" || c == "E" || c == "x" || c == "X" ||
               c == "f" || c == "F" || c == "l" || c == "L" || c == "u" || c == "U";
    endfunction

    // ------------------------------------------------------------------
    // style predictor
    // ------------------------------------------------------------------
    task automatic push_style(style_e s);
        clx_out_t r;
        r.style_code   = s;
        r.last_of_line = 1'b0;
        step_styles.push_back(r);
    endtask

    task automatic flush_word();
        style_e s;
        if (!word_long)
        begin
            s = is_keyword(word_pack) ? STY_KEYWORD : STY_NORMAL;
            repeat (word_len) push_style(s);
        end
        word_len  = 0;
        word_pack = '0;
        word_long = 1'b0;
        lx_mode   = LX_NORMAL;
    endtask

    // byte seen in normal mode with nothing held back
    task automatic start_token(logic [7:0] c);
        if (c == CH_SLASH || c == CH_DOT)
        begin
            held_chr = c;
            held_vld = 1'b1;
        end
        else if (c == CH_DQUOTE || c == CH_SQUOTE)
        begin
            push_style(STY_STRING);
            lx_mode     = (c == CH_DQUOTE) ? LX_DQ : LX_SQ;
            prev_bslash = 1'b0;
        end
        else if (is_dig(c))
        begin
            push_style(STY_NUMBER);
            lx_mode = LX_NUMBER;
        end
        else if (is_alpha(c) || c == CH_UNDER)
        begin
            word_pack = {56'd0, c};
            word_len  = 1;
            word_long = 1'b0;
            lx_mode   = LX_IDENT;
        end
        else
            push_style(STY_NORMAL);
    endtask

    task automatic literal_byte(logic [7:0] c, logic [7:0] quote);
        push_style(STY_STRING);
        if (c == quote && !prev_bslash)
        begin
            lx_mode     = LX_NORMAL;
            prev_bslash = 1'b0;
        end
        else
            prev_bslash = (c == CH_BSLASH);
    endtask

    task automatic clear_lexer();
        lx_mode     = LX_NORMAL;
        held_chr    = '0;
        held_vld    = 1'b0;
        word_pack   = '0;
        word_len    = 0;
        word_long   = 1'b0;
        prev_bslash = 1'b0;
        prev_star   = 1'b0;
    endtask

    // fills step_styles with the styles that one accepted byte releases
    task automatic classify_byte(logic [7:0] c, logic eol);
        logic [7:0] h;
        clx_out_t   r;
        step_styles.delete();
        case (lx_mode)
            LX_LINE:
                push_style(STY_COMMENT);
            LX_BLOCK:
            begin
                push_style(STY_COMMENT);
                if (c == CH_SLASH && prev_star)
                begin
                    lx_mode   = LX_NORMAL;
                    prev_star = 1'b0;
                end
                else
                    prev_star = (c == CH_STAR);
            end
            LX_DQ:
                literal_byte(c, CH_DQUOTE);
            LX_SQ:
                literal_byte(c, CH_SQUOTE);
            LX_NUMBER:
                if (is_num_char(c))
                    push_style(STY_NUMBER);
                else
                begin
                    lx_mode = LX_NORMAL;
                    start_token(c);
                end
            LX_IDENT:
                if (is_word(c))
                begin
                    if (word_long)
                        push_style(STY_NORMAL);
                    else if (word_len < WORD_MAX)
                    begin
                        word_pack = {word_pack[55:0], c};
                        word_len++;
                    end
                    else
                    begin
                        // buffer overflow: everything so far plus this byte is normal
                        repeat (word_len + 1) push_style(STY_NORMAL);
                        word_long = 1'b1;
                    end
                end
                else
                begin
                    flush_word();
                    start_token(c);
                end
            default:
            begin
                lx_mode = LX_NORMAL;
                if (held_vld)
                begin
                    h        = held_chr;
                    held_vld = 1'b0;
                    held_chr = '0;
                    if (h == CH_SLASH && c == CH_SLASH)
                    begin
                        repeat (2) push_style(STY_COMMENT);
                        lx_mode = LX_LINE;
                    end
                    else if (h == CH_SLASH && c == CH_STAR)
                    begin
                        // the opener star never counts toward the close
                        repeat (2) push_style(STY_COMMENT);
                        lx_mode   = LX_BLOCK;
                        prev_star = 1'b0;
                    end
                    else if (h == CH_DOT && is_dig(c))
                    begin
                        repeat (2) push_style(STY_NUMBER);
                        lx_mode = LX_NUMBER;
                    end
                    else
                    begin
                        push_style(STY_NORMAL);
                        start_token(c);
                    end
                end
                else
                    start_token(c);
            end
        endcase

        if (eol)
        begin
            if (held_vld)
                push_style(STY_NORMAL);
            if (lx_mode == LX_IDENT)
                flush_word();
            if (step_styles.size() > 0)
            begin
                r = step_styles.pop_back();
                r.last_of_line = 1'b1;
                step_styles.push_back(r);
            end
            clear_lexer();
        end
    endtask

    // ------------------------------------------------------------------
    // char side
    // ------------------------------------------------------------------
    // mostly back-to-back, some short gaps, a few long ones, and gapless stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if (r < 4)
        begin
            quiet_left = $urandom_range(15, 40);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // offer one byte, wait for its transaction, then predict it; valid stays
    // high across back-to-back bytes and only the caller ever lowers it for good
    task automatic send_byte(logic [7:0] c, logic eol, bit typed, style_e typed_style);
        clx_in_t  item;
        clx_out_t r;
        int       gap;
        item.char_code = c;
        item.line_end  = eol;
        char_data  <= item;
        char_valid <= 1'b1;
        do
            @(posedge clk);
        while (char_stall);

        classify_byte(c, eol);
        if (typed)
        begin
            // rows whose one style is obvious are checked against the typed value
            step_styles.delete();
            r.style_code   = typed_style;
            r.last_of_line = 1'b1;
            step_styles.push_back(r);
        end
        foreach (step_styles[k])
            pending_styles.push_back(step_styles[k]);
        bytes_sent++;
        if (eol)
            lines_sent++;

        gap = pick_gap();
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender stops until every expected style has arrived
    task automatic drain_styles();
        char_valid <= 1'b0;
        while (pending_styles.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_from(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // one random source line: mostly well-formed tokens, sometimes pure noise
    task automatic build_line();
        logic [63:0] w;
        int          ntok;
        int          n;
        line_buf.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 8);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        ntok = $urandom_range(1, 5);
        repeat (ntok)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    w = keyword_at($urandom_range(0, KEYWORD_COUNT - 1));
                    for (int k = 7; k >= 0; k--)
                        if (w[k*8 +: 8] != 8'd0)
                            line_buf.push_back(w[k*8 +: 8]);
                end
                1:
                begin
                    // short names mostly, now and then a longer one that may overflow the buffer
                    n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(7, 12);
                    line_buf.push_back(pick_from(alpha_chars));
                    repeat (n - 1) line_buf.push_back(pick_from(word_chars));
                end
                2:
                begin
                    line_buf.push_back(pick_from(digit_chars));
                    repeat ($urandom_range(0, 4)) line_buf.push_back(pick_from(num_chars));
                end
                3, 4:
                begin
                    w[7:0] = ($urandom_range(0, 1) == 0) ? CH_DQUOTE : CH_SQUOTE;
                    line_buf.push_back(w[7:0]);
                    repeat ($urandom_range(0, 5))
                    begin
                        if ($urandom_range(0, 5) == 0)
                        begin
                            line_buf.push_back(CH_BSLASH);
                            line_buf.push_back(pick_from(escape_chars));
                        end
                        else
                            line_buf.push_back(pick_from(text_chars));
                    end
                    if ($urandom_range(0, 6) != 0)
                        line_buf.push_back(w[7:0]);
                end
                5:
                begin
                    line_buf.push_back(CH_SLASH);
                    line_buf.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 5))
                        line_buf.push_back(8'($urandom_range(32, 126)));
                end
                6:
                begin
                    line_buf.push_back(CH_SLASH);
                    line_buf.push_back(CH_STAR);
                    repeat ($urandom_range(0, 5)) line_buf.push_back(pick_from(block_chars));
                    if ($urandom_range(0, 9) < 7)
                    begin
                        line_buf.push_back(CH_STAR);
                        line_buf.push_back(CH_SLASH);
                    end
                end
                7:
                    line_buf.push_back(pick_from(punct_chars));
                8:
                begin
                    line_buf.push_back(CH_DOT);
                    repeat ($urandom_range(1, 2)) line_buf.push_back(pick_from(digit_chars));
                end
                default:
                    line_buf.push_back(8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 9) < 4)
                line_buf.push_back(CH_SPACE);
        end
    endtask

    // ------------------------------------------------------------------
    // style side: random stalls, with one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        int n;
        style_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                // long hold-off: the queue fills and char_stall has to rise
                hold_off_req = 1'b0;
                style_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    style_stall <= 1'b0;
                    n = $urandom_range(1, 6);
                end
                else if (r < 85)
                begin
                    style_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end
                else if (r < 95)
                begin
                    style_stall <= 1'b1;
                    n = $urandom_range(6, 16);
                end
                else
                begin
                    style_stall <= 1'b0;
                    n = $urandom_range(20, 40);
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker: each style transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && style_valid && !style_stall)
        begin
            if (pending_styles.size() == 0)
            begin
                $error("unexpected style transaction: style_code %0d last_of_line %0d",
                       style_data.style_code, style_data.last_of_line);
                mismatches++;
            end
            else
            begin
                want_style = pending_styles.pop_front();
                styles_checked++;
                if (want_style.style_code == STY_KEYWORD)
                    keyword_styles++;
                if (style_data.style_code !== want_style.style_code)
                begin
                    $error("style_code: expected %0d, got %0d",
                           want_style.style_code, style_data.style_code);
                    mismatches++;
                end
                if (style_data.last_of_line !== want_style.last_of_line)
                begin
                    $error("last_of_line: expected %0d, got %0d",
                           want_style.last_of_line, style_data.last_of_line);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int  directed_bytes;
        bit  hold_issued;
        bit  drained;
        hold_issued = 1'b0;
        drained     = 1'b0;
        clear_lexer();

        rst_n      <= 1'b0;
        char_valid <= 1'b0;
        char_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
            send_byte(dir_rows[i].chr, dir_rows[i].eol, dir_rows[i].typed,
                      dir_rows[i].typed_style);
        directed_bytes = bytes_sent;
        drain_styles();

        // random source lines
        while (bytes_sent < directed_bytes + RANDOM_ITEMS)
        begin
            if (!hold_issued && bytes_sent >= directed_bytes + 30)
            begin
                hold_off_req = 1'b1;
                hold_issued  = 1'b1;
            end
            if (!drained && bytes_sent >= directed_bytes + 80)
            begin
                drain_styles();
                drained = 1'b1;
            end
            build_line();
            foreach (line_buf[j])
                send_byte(line_buf[j], j == line_buf.size() - 1, 1'b0, STY_NORMAL);
        end
        char_valid <= 1'b0;

        while (pending_styles.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d bytes in %0d lines (%0d from the directed table)",
                 bytes_sent, lines_sent, directed_bytes);
        $display("%0d style transactions checked, %0d of them keyword, %0d mismatches",
                 styles_checked, keyword_styles, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
